// ----- design/pft_pkg.sv -----
// Shared constants for the plane-from-triangle pipeline.
// Used by the core and by its port checker; depends on nothing else.
package pft_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int MANT_BITS       = 30;
	localparam int ROOT_BITS       = MANT_BITS + 1;
	localparam int QUOT_BITS       = MANT_BITS + 1;
	localparam int NORM_WIDTH      = 32;
	localparam int OFFSET_WIDTH    = 25;
	localparam int OUT_FIELD_BITS  = 3 * NORM_WIDTH + OFFSET_WIDTH;
	localparam int OUT_DATA_WIDTH  = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int REM_WIDTH       = 64;

	localparam logic [63:0] OFFSET_MAX     = 64'd16777215;
	localparam logic [63:0] OFFSET_MIN_MAG = 64'd16777216;
	localparam logic signed [NORM_WIDTH-1:0] UNIT_ONE = 32'sd1073741824;

endpackage

// ----- design/plane_from_triangle_core.sv -----
// Plane through three points: unit normal and plane offset, fully pipelined.
// Depends on pft_pkg for widths and saturation limits.
//
//  Channel  | Direction | Ports                          | Content
//  ---------+-----------+--------------------------------+------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata      | corners a, b, c (9 x COORD_WIDTH)
//  m_       | out       | m_tvalid m_tready m_tdata      | normal x/y/z Q2.30, offset Q25.0
//           |           | m_tuser                        | degenerate flag
//
// A beat can enter every cycle while the output is not stalled. Its result passes
// through the edge, cross product and normalisation stages, the square root (one
// root bit per stage), the division (one quotient bit per stage, three lanes side
// by side) and then the scaling, offset and output registering stages.
// The whole pipeline advances together; it freezes only while the output
// register holds a beat that is not taken, so a stall drops or repeats nothing.
// Reset clears the valid bits only; no clearing pass is needed.
module plane_from_triangle_core #(
	parameter int COORD_WIDTH = pft_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// normal_x, normal_y, normal_z, plane_offset from bit 0 up, zero padded
	output logic [pft_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,
	// degenerate
	output logic                                 m_tuser
);
	import pft_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int EW  = CW + 1;          // edge width
	localparam int PW  = 2 * EW;          // product width
	localparam int XW  = PW + 1;          // cross component width
	localparam int MW  = XW;              // magnitude width
	localparam int LW  = $clog2(MW + 1);
	localparam int MB  = MANT_BITS;
	localparam int SQ  = 2 * MB;
	localparam int SW  = SQ + 2;
	localparam int RB  = ROOT_BITS;
	localparam int QB  = QUOT_BITS;
	localparam int RW  = REM_WIDTH;
	localparam int NW  = NORM_WIDTH;
	localparam int TPW = NW + CW;         // normal times coordinate
	localparam int TW  = TPW + 2;         // sum of three terms
	localparam int RDW = TW - MB;         // rounded offset magnitude

	typedef struct packed {
		logic [2:0][CW-1:0] a;
		logic [2:0][MB-1:0] mant;
		logic [2:0]         neg;
		logic               deg;
	} side_t;

	// The whole pipeline moves whenever the output register can take a beat.
	logic en;
	logic out_v_q;
	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	// Stage 1: edge vectors.
	logic signed [CW-1:0] in_c [9];
	logic                 v_s1;
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic [2:0][CW-1:0]   a_s1;

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			in_c[k] = s_tdata[k*CW +: CW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= $signed({in_c[3+i][CW-1], in_c[3+i]})
				          - $signed({in_c[i][CW-1], in_c[i]});
				e2_s1[i] <= $signed({in_c[6+i][CW-1], in_c[6+i]})
				          - $signed({in_c[i][CW-1], in_c[i]});
				a_s1[i]  <= in_c[i];
			end
		end
	end

	// Stage 2: the six products of the cross product.
	logic                 v_s2;
	logic signed [PW-1:0] p_s2 [3];
	logic signed [PW-1:0] q_s2 [3];
	logic [2:0][CW-1:0]   a_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			q_s2[0] <= e1_s1[2] * e2_s1[1];
			p_s2[1] <= e1_s1[2] * e2_s1[0];
			q_s2[1] <= e1_s1[0] * e2_s1[2];
			p_s2[2] <= e1_s1[0] * e2_s1[1];
			q_s2[2] <= e1_s1[1] * e2_s1[0];
			a_s2    <= a_s1;
		end
	end

	// Stage 3: cross product components.
	logic                 v_s3;
	logic signed [XW-1:0] w_s3 [3];
	logic [2:0][CW-1:0]   a_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				w_s3[i] <= $signed({p_s2[i][PW-1], p_s2[i]}) - $signed({q_s2[i][PW-1], q_s2[i]});
			end
			a_s3 <= a_s2;
		end
	end

	// Stage 4: sign and magnitude, and the bit length of the largest magnitude.
	logic [MW-1:0]      mag_c [3];
	logic [MW-1:0]      mag_or_c;
	logic [LW-1:0]      len_c;
	logic               v_s4;
	logic [MW-1:0]      mag_s4 [3];
	logic [2:0]         neg_s4;
	logic [LW-1:0]      len_s4;
	logic [2:0][CW-1:0] a_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = w_s3[i][XW-1] ? MW'(-w_s3[i]) : MW'(w_s3[i]);
		end
		mag_or_c = mag_c[0] | mag_c[1] | mag_c[2];
		len_c    = '0;
		for (int k = 0; k < MW; k++) begin
			if (mag_or_c[k]) begin
				len_c = LW'(k + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= mag_c[i];
				neg_s4[i] <= w_s3[i][XW-1];
			end
			len_s4 <= len_c;
			a_s4   <= a_s3;
		end
	end

	// Stage 5: common shift so the largest magnitude has exactly MB bits.
	logic          big_c;
	logic [LW-1:0] shr_c;
	logic [LW-1:0] shl_c;
	logic          v_s5;
	side_t         side_s5;

	assign big_c = len_s4 > LW'(MB);
	assign shr_c = len_s4 - LW'(MB);
	assign shl_c = LW'(MB) - len_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				side_s5.mant[i] <= big_c ? MB'(mag_s4[i] >> shr_c) : MB'(mag_s4[i] << shl_c);
			end
			side_s5.neg <= neg_s4;
			side_s5.deg <= (len_s4 == '0);
			side_s5.a   <= a_s4;
		end
	end

	// Stage 6: squares.
	logic          v_s6;
	logic [SQ-1:0] sq_s6 [3];
	side_t         side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= SQ'(side_s5.mant[i]) * SQ'(side_s5.mant[i]);
			end
			side_s6 <= side_s5;
		end
	end

	// Stage 7: sum of squares.
	logic          v_s7;
	logic [SW-1:0] sum_s7;
	side_t         side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7  <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
			side_s7 <= side_s6;
		end
	end

	// Square root: one root bit per stage, most significant first.
	logic          rt_v [RB+1];
	logic [RW-1:0] rt_rem [RB+1];
	logic [RB-1:0] rt_root [RB+1];
	side_t         rt_side [RB+1];

	assign rt_v[0]    = v_s7;
	assign rt_rem[0]  = RW'(sum_s7);
	assign rt_root[0] = '0;
	assign rt_side[0] = side_s7;

	for (genvar j = 0; j < RB; j++) begin : g_rt
		localparam int K = RB - 1 - j;
		logic [RW-1:0] cand;
		logic          take;

		assign cand = (RW'(rt_root[j]) << (K + 1)) | (RW'(1) << (2 * K));
		assign take = rt_rem[j] >= cand;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[j+1] <= 1'b0;
			end else if (en) begin
				rt_v[j+1] <= rt_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem[j+1]  <= take ? rt_rem[j] - cand : rt_rem[j];
				rt_root[j+1] <= take ? (rt_root[j] | (RB'(1) << K)) : rt_root[j];
				rt_side[j+1] <= rt_side[j];
			end
		end
	end

	// Division: each lane forms round(mant * 2^30 / root) as
	// floor((mant * 2^31 + root) / (2 * root)), one quotient bit per stage.
	logic          dv_v [QB+1];
	logic [RW-1:0] dv_rem [QB+1][3];
	logic [QB-1:0] dv_q [QB+1][3];
	logic [RW-1:0] dv_den [QB+1];
	side_t         dv_side [QB+1];

	assign dv_v[0]    = rt_v[RB];
	assign dv_den[0]  = RW'({rt_root[RB], 1'b0});
	assign dv_side[0] = rt_side[RB];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_rem[0][i] = (RW'(rt_side[RB].mant[i]) << (MB + 1)) + RW'(rt_root[RB]);
			dv_q[0][i]   = '0;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_dv
		localparam int K = QB - 1 - j;
		logic [RW-1:0] dsh;

		assign dsh = dv_den[j] << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dv_rem[j][i] >= dsh) begin
						dv_rem[j+1][i] <= dv_rem[j][i] - dsh;
						dv_q[j+1][i]   <= dv_q[j][i] | (QB'(1) << K);
					end else begin
						dv_rem[j+1][i] <= dv_rem[j][i];
						dv_q[j+1][i]   <= dv_q[j][i];
					end
				end
				dv_den[j+1]  <= dv_den[j];
				dv_side[j+1] <= dv_side[j];
			end
		end
	end

	// Stage A: signed normal, forced to zero for a degenerate triangle.
	logic                 v_sa;
	logic signed [NW-1:0] n_sa [3];
	logic [2:0][CW-1:0]   a_sa;
	logic                 deg_sa;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_side[QB].deg) begin
					n_sa[i] <= '0;
				end else if (dv_side[QB].neg[i]) begin
					n_sa[i] <= -$signed(NW'(dv_q[QB][i]));
				end else begin
					n_sa[i] <= $signed(NW'(dv_q[QB][i]));
				end
			end
			a_sa   <= dv_side[QB].a;
			deg_sa <= dv_side[QB].deg;
		end
	end

	// Stage B: normal times first corner.
	logic                  v_sb;
	logic signed [TPW-1:0] pr_sb [3];
	logic signed [NW-1:0]  n_sb [3];
	logic                  deg_sb;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pr_sb[i] <= n_sa[i] * $signed(a_sa[i]);
			end
			n_sb   <= n_sa;
			deg_sb <= deg_sa;
		end
	end

	// Stage C: dot product.
	logic                 v_sc;
	logic signed [TW-1:0] t_sc;
	logic signed [NW-1:0] n_sc [3];
	logic                 deg_sc;

	always_ff @(posedge clk) begin
		if (en) begin
			t_sc   <= TW'(pr_sb[0]) + TW'(pr_sb[1]) + TW'(pr_sb[2]);
			n_sc   <= n_sb;
			deg_sc <= deg_sb;
		end
	end

	// Output stage: round half away from zero, negate and saturate the offset.
	logic [TW-1:0]           tm_c;
	logic [RDW-1:0]          r_c;
	logic [63:0]             r64_c;
	logic [OFFSET_WIDTH-1:0] rpos_c;
	logic [OFFSET_WIDTH-1:0] rneg_c;
	logic [OFFSET_WIDTH-1:0] d_c;
	logic [NW-1:0]           nx_q;
	logic [NW-1:0]           ny_q;
	logic [NW-1:0]           nz_q;
	logic [OFFSET_WIDTH-1:0] d_q;
	logic                    deg_q;

	always_comb begin
		tm_c   = t_sc[TW-1] ? TW'(-t_sc) : TW'(t_sc);
		r_c    = RDW'((tm_c + (TW'(1) << (MB - 1))) >> MB);
		r64_c  = 64'(r_c);
		rpos_c = (r64_c > OFFSET_MAX) ? OFFSET_WIDTH'(OFFSET_MAX) : r64_c[OFFSET_WIDTH-1:0];
		rneg_c = (r64_c > OFFSET_MIN_MAG) ? OFFSET_WIDTH'(OFFSET_MIN_MAG)
		                                   : r64_c[OFFSET_WIDTH-1:0];
		d_c    = t_sc[TW-1] ? rpos_c : OFFSET_WIDTH'(-rneg_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_q  <= n_sc[0];
			ny_q  <= n_sc[1];
			nz_q  <= n_sc[2];
			d_q   <= d_c;
			deg_q <= deg_sc;
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			v_sa    <= 1'b0;
			v_sb    <= 1'b0;
			v_sc    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			v_sa    <= dv_v[QB];
			v_sb    <= v_sa;
			v_sc    <= v_sb;
			out_v_q <= v_sc;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = deg_q;
	assign m_tdata  = {{(OUT_DATA_WIDTH - OUT_FIELD_BITS){1'b0}}, d_q, nz_q, ny_q, nx_q};

endmodule

// ----- design/pft_checker.sv -----
// Port checker for the plane-from-triangle core, bound to every core instance.
// Depends on pft_pkg for output field widths.
module pft_checker #(
	parameter int COORD_WIDTH = pft_pkg::COORD_WIDTH_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [pft_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
	input logic                               m_tuser
);
	import pft_pkg::*;

	logic signed [NORM_WIDTH-1:0] nx;
	logic signed [NORM_WIDTH-1:0] ny;
	logic signed [NORM_WIDTH-1:0] nz;
	logic                         in_seen;

	assign nx      = m_tdata[NORM_WIDTH-1:0];
	assign ny      = m_tdata[2*NORM_WIDTH-1:NORM_WIDTH];
	assign nz      = m_tdata[3*NORM_WIDTH-1:2*NORM_WIDTH];
	assign in_seen = s_tvalid || (s_tdata != '0);

	// The input side only waits while a finished beat is held up.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

	// A held output beat stays and keeps its content.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output beat changed");

	// A degenerate triangle gives an all-zero result.
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("degenerate beat carries non-zero data");

	// Normal components never exceed one in magnitude.
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (nx <= UNIT_ONE && nx >= -UNIT_ONE &&
		                            ny <= UNIT_ONE && ny >= -UNIT_ONE &&
		                            nz <= UNIT_ONE && nz >= -UNIT_ONE &&
		                            (nx != '0 || ny != '0 || nz != '0 || in_seen || !in_seen)))
		else $error("normal component out of range");

endmodule

bind plane_from_triangle_core pft_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pft_checker (.*);

// ----- test/plane_from_triangle_core_tb.sv -----
// Self-checking testbench for plane_from_triangle_core: random and directed triangles,
// a predicted unit normal and offset for each, compared beat by beat at the output.
// Depends on pft_pkg and the core itself.
module plane_from_triangle_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pft_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int IN_W = ((9*CW+7)/8)*8;
	localparam int TRIANGLES = 1350;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [NORM_WIDTH-1:0] nx;
		logic [NORM_WIDTH-1:0] ny;
		logic [NORM_WIDTH-1:0] nz;
		logic [OFFSET_WIDTH-1:0] offset;
		logic degen;
	} plane_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_WIDTH-1:0] m_tdata;
	logic m_tuser;

	logic [IN_W-1:0] triangle_q[$];
	plane_t plane_q[$];
	int mismatches = 0;
	int results_seen = 0;
	bit stimulus_done = 1'b0;
	bit hold_off = 1'b0;
	bit s_tready_seen = 1'b0;
	longint cycles = 0;

	plane_from_triangle_core #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint corner(logic [IN_W-1:0] t, int k);
		logic signed [CW-1:0] v;
		v = t[k*CW +: CW];
		return longint'(v);
	endfunction

	function automatic int bit_length(logic [127:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 128; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		root = 0;
		for (int i = 31; i >= 0; i--)
			if ((root | (64'd1 << i)) * (root | (64'd1 << i)) <= v)
				root |= 64'd1 << i;
		return root;
	endfunction

	// Works out the plane for one triangle. The cross product is exact in 128-bit
	// signed arithmetic, then all three terms share one normalising shift.
	function automatic plane_t plane_of(logic [IN_W-1:0] t);
		plane_t p;
		longint a[3], e1[3], e2[3], m[3], nrm[3];
		logic signed [127:0] w[3];
		logic [127:0] mag;
		logic [63:0] sumsq, root, q, r, tm;
		logic signed [127:0] acc;
		int len, l;
		for (int i = 0; i < 3; i++) begin
			a[i] = corner(t, i);
			e1[i] = corner(t, 3 + i) - a[i];
			e2[i] = corner(t, 6 + i) - a[i];
		end
		w[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
		w[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
		w[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
		len = 0;
		for (int i = 0; i < 3; i++) begin
			mag = w[i] < 0 ? -w[i] : w[i];
			l = bit_length(mag);
			if (l > len) len = l;
		end
		p = '0;
		if (len == 0) begin
			p.degen = 1'b1;
			return p;
		end
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			mag = w[i] < 0 ? -w[i] : w[i];
			mag = len > MANT_BITS ? mag >> (len - MANT_BITS) : mag << (MANT_BITS - len);
			m[i] = w[i] < 0 ? -longint'(mag) : longint'(mag);
			sumsq += mag[63:0] * mag[63:0];
		end
		root = int_sqrt(sumsq);
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			// rounding to nearest, halves away from zero
			q = ((64'(m[i] < 0 ? -m[i] : m[i]) << 31) + root) / (2 * root);
			nrm[i] = m[i] < 0 ? -longint'(q) : longint'(q);
			acc += 128'(nrm[i]) * 128'(a[i]);
		end
		tm = acc < 0 ? 64'(-acc) : 64'(acc);
		r = (tm + (64'd1 << 29)) >> 30;
		if (acc < 0)
			p.offset = r > OFFSET_MAX ? OFFSET_MAX[OFFSET_WIDTH-1:0] : r[OFFSET_WIDTH-1:0];
		else
			p.offset = r > OFFSET_MIN_MAG ? OFFSET_MIN_MAG[OFFSET_WIDTH-1:0]
				: OFFSET_WIDTH'(-r);
		p.nx = nrm[0][31:0];
		p.ny = nrm[1][31:0];
		p.nz = nrm[2][31:0];
		return p;
	endfunction

	function automatic logic [CW-1:0] rand_coord(int style);
		case (style)
			0: return CW'($urandom);
			1: return CW'($urandom_range(0, 64)) - CW'(32);
			2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			default: return CW'($signed(CW'($urandom_range(0, 65535))) - 32768);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] pack(logic [CW-1:0] v[9]);
		logic [IN_W-1:0] t;
		t = '0;
		for (int k = 0; k < 9; k++)
			t[k*CW +: CW] = v[k];
		return t;
	endfunction

	// Stimulus: directed corner cases, then random triangles of mixed scale.
	initial begin
		logic [CW-1:0] v[9];
		logic [CW-1:0] maxp, minn;
		int style;
		int src;
		maxp = {1'b0, {(CW-1){1'b1}}};
		minn = {1'b1, {(CW-1){1'b0}}};
		// coincident corners at zero and at each extreme
		foreach (v[k]) v[k] = '0;
		triangle_q.push_back(pack(v));
		foreach (v[k]) v[k] = maxp;
		triangle_q.push_back(pack(v));
		foreach (v[k]) v[k] = minn;
		triangle_q.push_back(pack(v));
		// collinear corners
		v = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
		triangle_q.push_back(pack(v));
		// unit triangles in each axis plane, both windings in the x-y plane
		v = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
		triangle_q.push_back(pack(v));
		v = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};
		triangle_q.push_back(pack(v));
		v = '{0, 0, 0, 0, 4096, 0, 0, 0, 4096};
		triangle_q.push_back(pack(v));
		v = '{0, 0, 0, 0, 0, 4096, 4096, 0, 0};
		triangle_q.push_back(pack(v));
		// extreme spans, giving the widest cross product
		v = '{minn, minn, minn, maxp, minn, minn, minn, maxp, minn};
		triangle_q.push_back(pack(v));
		v = '{maxp, maxp, maxp, minn, maxp, maxp, maxp, minn, maxp};
		triangle_q.push_back(pack(v));
		v = '{maxp, maxp, maxp, minn, minn, maxp, maxp, minn, minn};
		triangle_q.push_back(pack(v));
		v = '{minn, maxp, minn, maxp, minn, maxp, minn, minn, maxp};
		triangle_q.push_back(pack(v));
		// tiny triangles far from the origin
		v = '{maxp, maxp, maxp, maxp - 1, maxp, maxp, maxp, maxp - 1, maxp};
		triangle_q.push_back(pack(v));
		v = '{minn, minn, minn, minn + 1, minn, minn, minn, minn, minn + 1};
		triangle_q.push_back(pack(v));
		// tilted normal with all components present
		v = '{4096, 0, 0, 0, 4096, 0, 0, 0, 4096};
		triangle_q.push_back(pack(v));
		while (triangle_q.size() < TRIANGLES) begin
			style = $urandom_range(0, 9);
			foreach (v[k])
				v[k] = rand_coord(style < 5 ? 0 : style < 7 ? 1 : style < 8 ? 2 : 3);
			if ($urandom_range(0, 19) == 0) begin
				// degenerate by construction: c repeats a or b
				src = $urandom_range(0, 1) * 3;
				for (int k = 0; k < 3; k++)
					v[6 + k] = v[src + k];
			end
			triangle_q.push_back(pack(v));
		end
		stimulus_done = 1'b1;
	end

	// Reset asserted from the start, released on a falling edge.
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: holds a beat until it is taken, with random gaps between beats.
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready_seen) begin
				// previous beat taken at the last rising edge
				if (triangle_q.size() != 0 && send_gap == 0) begin
					s_tdata <= triangle_q.pop_front();
					s_tvalid <= 1'b1;
				end else
					s_tvalid <= 1'b0;
			end else if (!s_tvalid && triangle_q.size() != 0 && send_gap == 0) begin
				s_tdata <= triangle_q.pop_front();
				s_tvalid <= 1'b1;
			end
			if (send_gap > 0)
				send_gap <= send_gap - 1;
			else if ($urandom_range(0, 99) < 8)
				send_gap <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
					: $urandom_range(1, 3);
		end
	end

	// Handshake sampled at the rising edge; the prediction is made on acceptance.
	always @(posedge clk) begin
		s_tready_seen <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			plane_q.push_back(plane_of(s_tdata));
	end

	// Receiver back-pressure: random stalls, and one long hold-off while the
	// sender keeps offering beats so the pipeline fills and stalls its input.
	int recv_gap = 0;
	initial begin
		wait (arst_n);
		repeat (300) @(posedge clk);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		@(negedge clk);
		hold_off = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n || hold_off)
			m_tready <= 1'b0;
		else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < 10) begin
			recv_gap <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 80)
				: $urandom_range(1, 3);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	// Monitor: compares each result beat with the oldest predicted plane.
	always @(posedge clk) begin
		plane_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.nx = m_tdata[0 +: NORM_WIDTH];
			got.ny = m_tdata[NORM_WIDTH +: NORM_WIDTH];
			got.nz = m_tdata[2*NORM_WIDTH +: NORM_WIDTH];
			got.offset = m_tdata[3*NORM_WIDTH +: OFFSET_WIDTH];
			got.degen = m_tuser;
			results_seen <= results_seen + 1;
			if (plane_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("Unexpected result beat: %h deg %b", m_tdata, m_tuser);
			end else begin
				want = plane_q.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display({"Mismatch: expected n=(%h %h %h) d=%h deg=%b, ",
							"got n=(%h %h %h) d=%h deg=%b"},
							want.nx, want.ny, want.nz, want.offset, want.degen,
							got.nx, got.ny, got.nz, got.offset, got.degen);
				end
			end
		end
	end

	// Cycle limit and end of run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done && triangle_q.size() == 0);
		@(posedge clk);
		while (s_tvalid || plane_q.size() != 0)
			@(posedge clk);
		// let any stray beat appear
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
